### hdl/afc_pkg.sv
// Shared types and constants for the AABB frustum cull test block.
// Holds default parameters, action codes, stream field positions and the plane entry layout.
// No dependencies.
package afc_pkg;

  // Default parameter values for the top level
  localparam int unsigned PLANE_COUNT_DEF = 6;
  localparam int unsigned COORD_BITS_DEF  = 32;

  // Action codes carried in the input tuser
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TEST = 1'b1;

  // Input tdata layout, lowest bit first, no gaps
  localparam int unsigned SLOT_LSB   = 0;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned NX_LSB     = 3;
  localparam int unsigned NY_LSB     = 19;
  localparam int unsigned NZ_LSB     = 35;
  localparam int unsigned NORM_W     = 16;
  localparam int unsigned OFF_LSB    = 51;
  localparam int unsigned OFF_W      = 32;
  localparam int unsigned CX_LSB     = 83;
  localparam int unsigned CY_LSB     = 115;
  localparam int unsigned CZ_LSB     = 147;
  localparam int unsigned CTR_W      = 32;
  localparam int unsigned HX_LSB     = 179;
  localparam int unsigned HY_LSB     = 210;
  localparam int unsigned HZ_LSB     = 241;
  localparam int unsigned HALF_W     = 31;
  localparam int unsigned S_DATA_W   = 272;
  localparam int unsigned M_DATA_W   = 8;

  // One plane as stored in the plane memory
  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [NORM_W-1:0] nz;
    logic [NORM_W-1:0] ny;
    logic [NORM_W-1:0] nx;
  } plane_entry_t;

endpackage

### hdl/aabb_frustum_cull_test.sv
// Top level of the AABB frustum cull test: plane memory, one-plane-per-cycle
// evaluation pipeline and result register. Depends on afc_pkg.
//
// Usage: an input transaction with tuser = 0 loads plane slot plane_slot (slots at or beyond
// PLANE_COUNT are dropped) and produces no result; it completes in the accept cycle. A
// transaction with tuser = 1 tests a world-space box (center, half extents) against all planes
// and produces one output transaction whose bit 0 is 1 when -r <= dot(n, c) - offset holds for
// every plane. Planes sit in a small synchronous memory (one read port, registered read data);
// per-entry valid bits make unloaded planes read as zero, which always pass. A test walks the
// memory one plane per cycle through read, multiply, sum and compare stages; the final result is
// parked and then moved to the result register, and the next transaction is taken once the walk
// has drained and no result is parked. One box is in flight at a time: s_axis_tready drops while
// a test is in progress, which also keeps loads away from the entries a test is reading. The
// result register lets the next item be accepted while a result waits for m_axis_tready.
// All sums are exact (Q18.30), nothing rounds or saturates.
module aabb_frustum_cull_test
  import afc_pkg::*;
#(
  parameter int unsigned PLANE_COUNT = PLANE_COUNT_DEF,  // 1..8
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF    // 16..48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata from bit 0: plane_slot, normal_x, normal_y, normal_z, plane_offset,
  // center_x, center_y, center_z, half_x, half_y, half_z
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // tuser: action (0 load plane, 1 test box)
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata from bit 0: visible, then zero fill
  output logic [M_DATA_W-1:0] m_axis_tdata
);

  // Coordinate width actually used, product and sum widths derived from it
  localparam int unsigned CW   = (COORD_BITS > 32) ? 32 : COORD_BITS;
  localparam int unsigned PW   = CW + 17;
  localparam int unsigned SUMW = PW + 3;
  localparam int unsigned SW   = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam logic [SW-1:0] LAST_IDX = SW'(PLANE_COUNT - 1);

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic              in_fire;
  logic              load_fire;
  logic              test_fire;
  logic [SLOT_W-1:0] slot;
  logic              slot_ok;
  plane_entry_t      wr_entry;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign load_fire = in_fire && (s_axis_tuser == ACT_LOAD);
  assign test_fire = in_fire && (s_axis_tuser == ACT_TEST);

  assign slot    = s_axis_tdata[SLOT_LSB +: SLOT_W];
  assign slot_ok = ({1'b0, slot} < 4'(PLANE_COUNT));

  assign wr_entry.nx     = s_axis_tdata[NX_LSB +: NORM_W];
  assign wr_entry.ny     = s_axis_tdata[NY_LSB +: NORM_W];
  assign wr_entry.nz     = s_axis_tdata[NZ_LSB +: NORM_W];
  assign wr_entry.offset = s_axis_tdata[OFF_LSB +: OFF_W];

  // ---------------------------------------------------------------------------
  // Plane memory with per-entry valid bits
  // ---------------------------------------------------------------------------
  plane_entry_t           plane_mem [PLANE_COUNT];
  logic [PLANE_COUNT-1:0] valid_q;
  plane_entry_t           rd_data_q;
  logic [SW-1:0]          idx_q;

  always_ff @(posedge clk_i) begin
    if (load_fire && slot_ok) begin
      plane_mem[slot[SW-1:0]] <= wr_entry;
    end
    rd_data_q <= plane_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (load_fire && slot_ok) begin
      valid_q[slot[SW-1:0]] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Box capture and plane sequencer
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] ctr_q  [3];
  logic        [CW-2:0] half_q [3];
  logic                 issue_q;

  always_ff @(posedge clk_i) begin
    if (test_fire) begin
      ctr_q[0]  <= s_axis_tdata[CX_LSB +: CW];
      ctr_q[1]  <= s_axis_tdata[CY_LSB +: CW];
      ctr_q[2]  <= s_axis_tdata[CZ_LSB +: CW];
      half_q[0] <= s_axis_tdata[HX_LSB +: (CW-1)];
      half_q[1] <= s_axis_tdata[HY_LSB +: (CW-1)];
      half_q[2] <= s_axis_tdata[HZ_LSB +: (CW-1)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      idx_q   <= '0;
    end else if (test_fire) begin
      issue_q <= 1'b1;
      idx_q   <= '0;
    end else if (issue_q) begin
      if (idx_q == LAST_IDX) begin
        issue_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: memory read
  // ---------------------------------------------------------------------------
  logic rd_v_q;
  logic rd_last_q;
  logic rd_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q    <= 1'b0;
      rd_last_q <= 1'b0;
      rd_ok_q   <= 1'b0;
    end else begin
      rd_v_q    <= issue_q;
      rd_last_q <= issue_q && (idx_q == LAST_IDX);
      rd_ok_q   <= valid_q[idx_q];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: products (six independent multipliers, one level deep)
  // ---------------------------------------------------------------------------
  plane_entry_t               pl;
  logic signed [NORM_W-1:0]   nrm [3];
  logic signed [NORM_W:0]     nrm_ext;
  logic signed [NORM_W:0]     nrm_abs [3];
  logic signed [CW-1:0]       half_s [3];
  logic signed [CW-1:0]       off_cw;
  logic signed [PW-1:0]       ps_d [3];
  logic signed [PW-1:0]       pr_d [3];
  logic signed [PW-1:0]       ps_q [3];
  logic signed [PW-1:0]       pr_q [3];
  logic signed [CW+13:0]      off_d;
  logic signed [CW+13:0]      off_q;
  logic                       mul_v_q;
  logic                       mul_last_q;

  always_comb begin
    // Drop never-loaded entries to the zero plane
    pl     = rd_ok_q ? rd_data_q : '0;
    nrm[0] = pl.nx;
    nrm[1] = pl.ny;
    nrm[2] = pl.nz;
    off_cw = pl.offset[CW-1:0];
    off_d  = {off_cw, 14'b0};
    for (int k = 0; k < 3; k++) begin
      nrm_ext    = (NORM_W+1)'(nrm[k]);
      nrm_abs[k] = nrm[k][NORM_W-1] ? -nrm_ext : nrm_ext;
      half_s[k]  = {1'b0, half_q[k]};
      ps_d[k]    = PW'(nrm[k]) * PW'(ctr_q[k]);
      pr_d[k]    = PW'(nrm_abs[k]) * PW'(half_s[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    ps_q  <= ps_d;
    pr_q  <= pr_d;
    off_q <= off_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q    <= 1'b0;
      mul_last_q <= 1'b0;
    end else begin
      mul_v_q    <= rd_v_q;
      mul_last_q <= rd_v_q && rd_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: signed distance and projected radius
  // ---------------------------------------------------------------------------
  logic signed [SUMW-1:0] dist_d;
  logic signed [SUMW-1:0] rad_d;
  logic signed [SUMW-1:0] dist_q;
  logic signed [SUMW-1:0] rad_q;
  logic                   sum_v_q;
  logic                   sum_last_q;

  assign dist_d = SUMW'(ps_q[0]) + SUMW'(ps_q[1]) + SUMW'(ps_q[2]) - SUMW'(off_q);
  assign rad_d  = SUMW'(pr_q[0]) + SUMW'(pr_q[1]) + SUMW'(pr_q[2]);

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    rad_q  <= rad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_v_q    <= 1'b0;
      sum_last_q <= 1'b0;
    end else begin
      sum_v_q    <= mul_v_q;
      sum_last_q <= mul_v_q && mul_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: compare, accumulate visibility, park the result
  // ---------------------------------------------------------------------------
  logic signed [SUMW:0] margin;
  logic                 vis_now;
  logic                 vis_acc_q;
  logic                 pend_q;
  logic                 pend_vis_q;

  assign margin  = (SUMW+1)'(dist_q) + (SUMW+1)'(rad_q);
  assign vis_now = vis_acc_q && !margin[SUMW];

  logic out_v_q;
  logic out_vis_q;
  logic out_free;

  assign out_free = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_acc_q  <= 1'b1;
      pend_q     <= 1'b0;
      pend_vis_q <= 1'b0;
    end else begin
      if (test_fire) begin
        vis_acc_q <= 1'b1;
      end else if (sum_v_q) begin
        vis_acc_q <= vis_now;
      end
      if (sum_v_q && sum_last_q) begin
        pend_q     <= 1'b1;
        pend_vis_q <= vis_now;
      end else if (pend_q && out_free) begin
        pend_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      out_vis_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= pend_q;
      if (pend_q) begin
        out_vis_q <= pend_vis_q;
      end
    end
  end

  logic busy;
  assign busy = issue_q || rd_v_q || mul_v_q || sum_v_q || pend_q;

  assign s_axis_tready = !busy;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {(M_DATA_W-1)'(0), out_vis_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !(issue_q || rd_v_q || mul_v_q || sum_v_q || pend_q))
    else $error("input ready while a test is in flight");

  a_one_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({rd_v_q && rd_last_q, mul_v_q && mul_last_q, sum_v_q && sum_last_q, pend_q}))
    else $error("more than one final plane in flight");

  a_test_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    test_fire |=> (issue_q && (idx_q == '0)))
    else $error("accepted test did not start the plane walk");

  a_pend_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && out_free) |=> (!pend_q && out_v_q))
    else $error("parked result not moved to output register");

endmodule

### dv/testbench.sv
// Self-checking testbench for the six-plane AABB frustum cull block.
// Drives plane loads and box tests over the input stream, predicts visibility
// and checks each output transaction. Depends on afc_pkg and the block RTL.
module testbench;
  import afc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 32;  // margin for stray results after the owed ones drain
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned SLOT_STORE   = 8;   // every value the slot field can take
  localparam logic [15:0] UNIT_POS     = 16'h4000;  // +1.0 in Q2.14
  localparam logic [15:0] UNIT_NEG     = 16'hC000;  // -1.0 in Q2.14

  // How the planes of one frustum are built
  typedef enum int {FR_AXIS, FR_TILTED, FR_NOISE} frustum_kind_e;

  // One input transaction, unpacked field by field
  typedef struct {
    logic        action;
    logic [2:0]  slot;
    logic [15:0] nx, ny, nz;
    logic [31:0] offset;
    logic [31:0] cx, cy, cz;
    logic [30:0] hx, hy, hz;
  } cull_item_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;

  // Predictor state: the plane store as the block should hold it
  plane_entry_t        frustum_planes [SLOT_STORE];
  // Visibility bytes still owed by the block, oldest first
  logic [M_DATA_W-1:0] visible_fifo [$];
  logic [M_DATA_W-1:0] visible_due;

  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned hold_left;
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  aabb_frustum_cull_test i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Item construction
  // ---------------------------------------------------------------------------

  // Fill every field with random bits; fields that the action does not use
  // keep this noise, so the block is always shown garbage it has to ignore.
  function automatic cull_item_t noise_item(input logic action);
    cull_item_t  it;
    logic [31:0] r;
    it.action = action;
    r = $urandom;  it.slot = r[2:0];
    r = $urandom;  it.nx = r[15:0];  it.ny = r[31:16];
    r = $urandom;  it.nz = r[15:0];
    it.offset = $urandom;
    it.cx = $urandom;
    it.cy = $urandom;
    it.cz = $urandom;
    r = $urandom;  it.hx = r[30:0];
    r = $urandom;  it.hy = r[30:0];
    r = $urandom;  it.hz = r[30:0];
    return it;
  endfunction

  function automatic cull_item_t plane_item(input logic [2:0] slot, input logic [15:0] nx,
                                            input logic [15:0] ny, input logic [15:0] nz,
                                            input logic [31:0] offset);
    cull_item_t it;
    it = noise_item(ACT_LOAD);
    it.slot = slot;
    it.nx = nx;
    it.ny = ny;
    it.nz = nz;
    it.offset = offset;
    return it;
  endfunction

  function automatic cull_item_t box_item(input logic [31:0] cx, input logic [31:0] cy,
                                          input logic [31:0] cz, input logic [31:0] hx,
                                          input logic [31:0] hy, input logic [31:0] hz);
    cull_item_t it;
    it = noise_item(ACT_TEST);
    it.cx = cx;
    it.cy = cy;
    it.cz = cz;
    it.hx = hx[30:0];
    it.hy = hy[30:0];
    it.hz = hz[30:0];
    return it;
  endfunction

  // One plane of a frustum around the origin. Axis frusta form the cube
  // [-span, span]^3; tilted ones keep the origin inside.
  function automatic cull_item_t frustum_plane(input frustum_kind_e kind,
                                               input logic [2:0] slot, input int unsigned span);
    cull_item_t  it;
    logic [15:0] n [3];
    int          v;
    case (kind)
      FR_AXIS: begin
        n[0] = '0;
        n[1] = '0;
        n[2] = '0;
        case (slot)
          3'd0:    n[0] = UNIT_POS;  // left
          3'd1:    n[0] = UNIT_NEG;  // right
          3'd2:    n[1] = UNIT_NEG;  // top
          3'd3:    n[1] = UNIT_POS;  // bottom
          3'd4:    n[2] = UNIT_POS;  // near
          default: n[2] = UNIT_NEG;  // far
        endcase
        it = plane_item(slot, n[0], n[1], n[2], -int'(span));
      end
      FR_TILTED: begin
        for (int k = 0; k < 3; k++) begin
          v = int'($urandom_range(32768)) - 16384;
          n[k] = v[15:0];
        end
        it = plane_item(slot, n[0], n[1], n[2], -int'($urandom_range(span)));
      end
      default: begin
        it = noise_item(ACT_LOAD);
        it.slot = slot;
      end
    endcase
    return it;
  endfunction

  // Mostly boxes scattered around the frustum boundary, some pure noise.
  function automatic cull_item_t scatter_box(input int unsigned span);
    int c [3];
    if ($urandom_range(99) < 15) begin
      return noise_item(ACT_TEST);
    end
    for (int k = 0; k < 3; k++) begin
      c[k] = int'($urandom_range(4 * span)) - int'(2 * span);
    end
    return box_item(c[0], c[1], c[2], $urandom_range(span), $urandom_range(span),
                    $urandom_range(span));
  endfunction

  function automatic logic [S_DATA_W-1:0] pack_item(input cull_item_t it);
    logic [S_DATA_W-1:0] d;
    d = '0;
    d[SLOT_LSB +: SLOT_W] = it.slot;
    d[NX_LSB +: NORM_W]   = it.nx;
    d[NY_LSB +: NORM_W]   = it.ny;
    d[NZ_LSB +: NORM_W]   = it.nz;
    d[OFF_LSB +: OFF_W]   = it.offset;
    d[CX_LSB +: CTR_W]    = it.cx;
    d[CY_LSB +: CTR_W]    = it.cy;
    d[CZ_LSB +: CTR_W]    = it.cz;
    d[HX_LSB +: HALF_W]   = it.hx;
    d[HY_LSB +: HALF_W]   = it.hy;
    d[HZ_LSB +: HALF_W]   = it.hz;
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Exact Q18.30 test of the box against every plane: the box survives a
  // plane when signed distance plus projected radius stays non-negative.
  function automatic logic [M_DATA_W-1:0] box_in_frustum(input cull_item_t it);
    longint c [3];
    longint h [3];
    longint n [3];
    longint reach;
    longint sdist;
    logic   vis;
    c[0] = longint'($signed(it.cx));
    c[1] = longint'($signed(it.cy));
    c[2] = longint'($signed(it.cz));
    h[0] = longint'(it.hx);
    h[1] = longint'(it.hy);
    h[2] = longint'(it.hz);
    vis = 1'b1;
    for (int p = 0; p < PLANE_COUNT_DEF; p++) begin
      n[0] = longint'($signed(frustum_planes[p].nx));
      n[1] = longint'($signed(frustum_planes[p].ny));
      n[2] = longint'($signed(frustum_planes[p].nz));
      reach = magnitude(n[0]) * h[0] + magnitude(n[1]) * h[1] + magnitude(n[2]) * h[2];
      sdist = n[0] * c[0] + n[1] * c[1] + n[2] * c[2]
            - longint'($signed(frustum_planes[p].offset)) * 16384;
      if (sdist + reach < 0) begin
        vis = 1'b0;
      end
    end
    return {{(M_DATA_W-1){1'b0}}, vis};
  endfunction

  // Apply one accepted transaction: store a plane, or owe a visibility result.
  task automatic apply_transaction(input cull_item_t it);
    if (it.action == ACT_TEST) begin
      visible_fifo.push_back(box_in_frustum(it));
    end else if (it.slot < PLANE_COUNT_DEF) begin
      frustum_planes[it.slot] = '{offset: it.offset, nz: it.nz, ny: it.ny, nx: it.nx};
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one transaction. Entered and left at a falling edge; idle cycles
  // come first, then tvalid holds until the block takes the transaction.
  task automatic send_item(input cull_item_t it);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.action;
    s_axis_tdata  <= pack_item(it);
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    apply_transaction(it);
    @(negedge clk_i);
  endtask

  // Boxes against planes that were never loaded: zero planes pass anything,
  // including the most extreme centers and extents.
  task automatic test_unloaded_planes();
    send_item(box_item('0, '0, '0, '0, '0, '0));
    send_item(box_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(box_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0, '0, '0));
  endtask

  // Loads beyond the last plane must be dropped; these planes would cull the box
  // at the origin that follows if they were stored.
  task automatic test_ignored_slots();
    send_item(plane_item(3'd6, 16'h8000, 16'h8000, 16'h8000, 32'h7FFF_FFFF));
    send_item(plane_item(3'd7, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF));
    send_item(box_item('0, '0, '0, '0, '0, '0));
  endtask

  // Extreme normals and offsets, then the cube frustum with a box exactly on
  // the boundary (still visible) and one unit past it (culled).
  task automatic test_extreme_planes();
    send_item(plane_item(3'd0, 16'h8000, 16'h7FFF, 16'h8000, 32'h7FFF_FFFF));
    send_item(box_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(box_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0, '0, '0));
    send_item(plane_item(3'd5, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h8000_0000));
    send_item(box_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '0, 32'h7FFF_FFFF, '0));
    for (int p = 0; p < PLANE_COUNT_DEF; p++) begin
      send_item(frustum_plane(FR_AXIS, p[2:0], 32'h0001_0000));
    end
    send_item(box_item(32'h0001_8000, '0, '0, 32'h8000, 32'h8000, 32'h8000));
    send_item(box_item(32'h0001_8001, '0, '0, 32'h8000, 32'h8000, 32'h8000));
    send_item(box_item('0, '0, 32'hFFFE_7FFF, 32'h8000, 32'h8000, 32'h8000));
  endtask

  // Hold the output off for a long stretch while boxes keep coming, so the
  // result register fills and the block has to stall its input.
  task automatic test_output_hold();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 400;
    repeat (40) begin
      send_item(scatter_box(32'h0001_0000));
    end
  endtask

  // Random frusta, each followed by a burst of boxes. Loads to slots past
  // the last plane are extra noise and are not counted.
  task automatic test_random_frusta(input int unsigned idle_pct, input int unsigned stall,
                                    input int unsigned item_total);
    int unsigned   sent;
    int unsigned   span;
    frustum_kind_e kind;
    logic [31:0]   r;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    sent = 0;
    while (sent < item_total) begin
      kind = frustum_kind_e'($urandom_range(2));
      span = $urandom_range(32'h0000_1000, 32'h0100_0000);
      if ($urandom_range(9) < 7) begin
        for (int p = 0; p < PLANE_COUNT_DEF; p++) begin
          send_item(frustum_plane(kind, p[2:0], span));
        end
        sent += PLANE_COUNT_DEF;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          r = $urandom_range(PLANE_COUNT_DEF - 1);
          send_item(frustum_plane(kind, r[2:0], span));
          sent++;
        end
      end
      if ($urandom_range(9) < 2) begin
        r = $urandom_range(7, PLANE_COUNT_DEF);
        send_item(frustum_plane(FR_NOISE, r[2:0], span));
      end
      repeat ($urandom_range(8, 30)) begin
        send_item(scatter_box(span));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Random stalls; a pending hold-off request overrides them and counts down.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic note_mismatch(input logic [M_DATA_W-1:0] want, input logic [M_DATA_W-1:0] got,
                               input bit orphan);
    if (mismatch_count < MAX_REPORTS) begin
      if (orphan) begin
        $display("[%0d] unexpected result transaction, visible byte %h", cycle_count, got);
      end else begin
        $display("[%0d] visible byte: expected %h, got %h", cycle_count, want, got);
      end
    end
    mismatch_count++;
  endtask

  // Compare each result transaction with the oldest owed visibility byte.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (visible_fifo.size() == 0) begin
        note_mismatch('0, m_axis_tdata, 1'b1);
      end else begin
        visible_due = visible_fifo.pop_front();
        if (m_axis_tdata !== visible_due) begin
          note_mismatch(visible_due, m_axis_tdata, 1'b0);
        end
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tuser   = ACT_LOAD;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    hold_left      = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    for (int p = 0; p < SLOT_STORE; p++) begin
      frustum_planes[p] = '0;
    end
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_unloaded_planes();
    test_ignored_slots();
    test_extreme_planes();
    test_output_hold();
    // Idle phases: none, sender gaps, receiver stalls, both
    test_random_frusta(0, 0, 450);
    test_random_frusta(55, 0, 450);
    test_random_frusta(0, 55, 450);
    test_random_frusta(32, 32, 450);

    // Drop tvalid, drain the owed results, then give stray results a chance
    s_axis_tvalid <= 1'b0;
    while (visible_fifo.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
